// File: rtl/ddt_pkg.sv
// ----------------------------------------------------------------------------
// ddt_pkg
// Shared types and constants for the discovery dedup table.
// ----------------------------------------------------------------------------
`default_nettype none

package ddt_pkg;

    localparam int TABLE_DEPTH_DEF   = 16;
    localparam int NODE_ID_BYTES_DEF = 3;

    localparam int OP_W    = 2;
    localparam int ID_W    = 24;
    localparam int BYTE_W  = 8;
    localparam int RSSI_W  = 16;
    localparam int TIME_W  = 32;
    localparam int IDX_W   = 4;
    localparam int PHASE_W = 2;
    localparam int CNT_W_DEF = 5;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESP  = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_DISC  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_FOUND = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]          node_id;
        logic [BYTE_W-1:0]        dev_type;
        logic [BYTE_W-1:0]        maker;
        logic [BYTE_W-1:0]        version;
        logic signed [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0]        stamp;
    } t_entry;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [ID_W-1:0]          node_id;
        logic [BYTE_W-1:0]        payload_len;
        logic [BYTE_W-1:0]        data0;
        logic [BYTE_W-1:0]        data1;
        logic [BYTE_W-1:0]        data2;
        logic signed [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0]        time_ms;
        logic [IDX_W-1:0]         index;
    } t_req;

endpackage

`default_nettype wire

// File: rtl/ddt_req_if.sv
// ----------------------------------------------------------------------------
// ddt_req_if
// Request channel carrying one table operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddt_req_if;
    import ddt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [ID_W-1:0]          node_id;
    logic [BYTE_W-1:0]        payload_len;
    logic [BYTE_W-1:0]        data0;
    logic [BYTE_W-1:0]        data1;
    logic [BYTE_W-1:0]        data2;
    logic signed [RSSI_W-1:0] rssi;
    logic [TIME_W-1:0]        time_ms;
    logic [IDX_W-1:0]         index;

    modport source (output valid, op, node_id, payload_len, data0, data1, data2, rssi,
                    time_ms, index, input ready);
    modport sink   (input valid, op, node_id, payload_len, data0, data1, data2, rssi,
                    time_ms, index, output ready);
endinterface

`default_nettype wire

// File: rtl/ddt_rsp_if.sv
// ----------------------------------------------------------------------------
// ddt_rsp_if
// Response channel carrying the result of one table operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddt_rsp_if #(
    parameter int CNT_W = ddt_pkg::CNT_W_DEF
);
    import ddt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic [CNT_W-1:0]         count;
    logic [PHASE_W-1:0]       phase;
    logic [ID_W-1:0]          entry_node_id;
    logic [BYTE_W-1:0]        entry_type;
    logic [BYTE_W-1:0]        entry_maker;
    logic [BYTE_W-1:0]        entry_version;
    logic signed [RSSI_W-1:0] entry_rssi;
    logic [TIME_W-1:0]        entry_time;

    modport source (output valid, accepted, count, phase, entry_node_id, entry_type,
                    entry_maker, entry_version, entry_rssi, entry_time, input ready);
    modport sink   (input valid, accepted, count, phase, entry_node_id, entry_type,
                    entry_maker, entry_version, entry_rssi, entry_time, output ready);
endinterface

`default_nettype wire

// File: rtl/ddt_cfg_if.sv
// ----------------------------------------------------------------------------
// ddt_cfg_if
// Write channel for the fallback device type register.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddt_cfg_if;
    import ddt_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/ddt_cell.sv
// ----------------------------------------------------------------------------
// ddt_cell
// One table slot: stores an entry, extends the id match chain and the read
// data chain toward its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ddt_cell
    import ddt_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_wr,
    input  wire t_entry          i_entry,
    input  wire logic [ID_W-1:0] i_key,
    input  wire logic            i_live,
    input  wire logic            i_rd_sel,
    input  wire logic            i_match,
    input  wire t_entry          i_rd,
    output logic                 o_match,
    output t_entry               o_rd
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_entry <= i_entry;
        end
    end

    assign o_match = i_match | (i_live & (r_entry.node_id == i_key));
    assign o_rd    = i_rd_sel ? r_entry : i_rd;

endmodule

`default_nettype wire

// File: rtl/discovery_dedup_table.sv
// ----------------------------------------------------------------------------
// discovery_dedup_table
// A taken request is held in the input register, makes one pass through the row
// of table cells and is then registered onto the response channel. No new request
// is taken while one is held there; a pending unread response stalls it.
// Reset clears the phase, the entry count, the fallback type and both channels;
// table slots hold no defined value until written.
// ----------------------------------------------------------------------------
`default_nettype none

module discovery_dedup_table
    import ddt_pkg::*;
#(
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
    parameter int NODE_ID_BYTES = NODE_ID_BYTES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ddt_cfg_if.sink   i_cfg,
    ddt_req_if.sink   i_req,
    ddt_rsp_if.source o_rsp
);

    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_BITS = (NODE_ID_BYTES * 8 < ID_W) ? NODE_ID_BYTES * 8 : ID_W;
    localparam logic [ID_W-1:0] ID_MASK =
        (KEY_BITS >= ID_W) ? {ID_W{1'b1}} : ((ID_W'(1) << KEY_BITS) - ID_W'(1));

    logic [BYTE_W-1:0]  r_fallback;
    logic               r_busy;
    t_req               r_req;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [CNT_W-1:0]   r_count, n_count;

    logic               r_out_valid;
    logic               r_out_acc, n_out_acc;
    logic [CNT_W-1:0]   r_out_count;
    logic [PHASE_W-1:0] r_out_phase;
    t_entry             r_out_entry;

    logic               exec;
    logic [ID_W-1:0]    key;
    logic               full;
    logic               store;
    logic               rd_ok;
    t_entry             new_entry;

    logic   match_chain [0:TABLE_DEPTH];
    t_entry rd_chain    [0:TABLE_DEPTH];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fallback <= '0;
        end else if (i_cfg.valid) begin
            r_fallback <= i_cfg.data;
        end
    end

    assign i_req.ready = !r_busy;
    assign exec        = r_busy && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.valid && !r_busy) begin
            r_busy <= 1'b1;
        end else if (exec) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && !r_busy) begin
            r_req.op          <= i_req.op;
            r_req.node_id     <= i_req.node_id;
            r_req.payload_len <= i_req.payload_len;
            r_req.data0       <= i_req.data0;
            r_req.data1       <= i_req.data1;
            r_req.data2       <= i_req.data2;
            r_req.rssi        <= i_req.rssi;
            r_req.time_ms     <= i_req.time_ms;
            r_req.index       <= i_req.index;
        end
    end

    assign key  = r_req.node_id & ID_MASK;
    assign full = (r_count == CNT_W'(TABLE_DEPTH));

    always_comb begin
        new_entry.node_id = key;
        if (r_req.payload_len >= BYTE_W'(2)) begin
            new_entry.dev_type = r_req.data0;
            new_entry.maker    = r_req.data1;
        end else begin
            new_entry.dev_type = r_fallback;
            new_entry.maker    = '0;
        end
        new_entry.version = (r_req.payload_len >= BYTE_W'(3)) ? r_req.data2 : '0;
        new_entry.rssi    = r_req.rssi;
        new_entry.stamp   = r_req.time_ms;
    end

    assign match_chain[0] = 1'b0;
    assign rd_chain[0]    = '0;

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        logic live;
        logic wr;
        logic rd_sel;

        assign live   = (CNT_W'(k) < r_count);
        assign wr     = exec && store && (r_count == CNT_W'(k));
        assign rd_sel = live && (r_req.op == OP_READ) &&
                        ({{(32 - IDX_W){1'b0}}, r_req.index} == 32'(k));

        ddt_cell u_cell (
            .i_clk    (i_clk),
            .i_wr     (wr),
            .i_entry  (new_entry),
            .i_key    (key),
            .i_live   (live),
            .i_rd_sel (rd_sel),
            .i_match  (match_chain[k]),
            .i_rd     (rd_chain[k]),
            .o_match  (match_chain[k+1]),
            .o_rd     (rd_chain[k+1])
        );
    end

    assign store = (r_req.op == OP_RESP) && (r_phase != PH_IDLE) && !full &&
                   !match_chain[TABLE_DEPTH];
    assign rd_ok = ({{(32 - IDX_W){1'b0}}, r_req.index} < {{(32 - CNT_W){1'b0}}, r_count});

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_out_acc = 1'b0;
        case (r_req.op)
            OP_START: begin
                n_phase = PH_DISC;
                n_count = '0;
            end
            OP_STOP: begin
                n_phase = PH_IDLE;
            end
            OP_RESP: begin
                if (store) begin
                    n_phase   = PH_FOUND;
                    n_count   = r_count + CNT_W'(1);
                    n_out_acc = 1'b1;
                end
            end
            OP_READ: begin
                n_out_acc = rd_ok;
            end
            default: begin
                n_out_acc = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (exec) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out_acc   <= n_out_acc;
            r_out_count <= n_count;
            r_out_phase <= n_phase;
            r_out_entry <= rd_chain[TABLE_DEPTH];
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.accepted      = r_out_acc;
    assign o_rsp.count         = r_out_count;
    assign o_rsp.phase         = r_out_phase;
    assign o_rsp.entry_node_id = r_out_entry.node_id;
    assign o_rsp.entry_type    = r_out_entry.dev_type;
    assign o_rsp.entry_maker   = r_out_entry.maker;
    assign o_rsp.entry_version = r_out_entry.version;
    assign o_rsp.entry_rssi    = r_out_entry.rssi;
    assign o_rsp.entry_time    = r_out_entry.stamp;

endmodule

`default_nettype wire
